// ===== sv/extent_block_allocator_core_defines.svh =====
// Assertion macros for the extent allocator
`ifndef EXTENT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define EXTENT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, clocked on aclk, quiet in reset
`define EBA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define EBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/eba_pkg.sv =====
// Shared constants and types for the extent allocator
package eba_pkg;
    localparam int MAX_EXTENTS = 64;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_BADCOUNT = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_OVERLAP  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    typedef struct packed {
        logic [31:0] low;
        logic [31:0] high;
    } extent_t;
endpackage

// ===== sv/extent_block_allocator_core.sv =====
// Extent free-list allocator: sorted extent table in one synchronous RAM
// Allocate reads and checks extents in turn; free scans for the first extent whose end is not
//   below the freed address; a whole take, an insert or a two-sided merge adds a shift pass.
// One request at a time; s_ready returns as the result registers into m_valid, and S_RESP
//   holds while an earlier result still waits for m_ready.
// Reset clears the extent count, free total, config registers and handshakes; RAM is not cleared.
`include "extent_block_allocator_core_defines.svh"
module extent_block_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [31:0] s_block_addr,
    input  logic [15:0] s_count,
    input  logic        s_from_tail,
    input  logic        s_superpage,
    input  logic        s_recovery,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_granted_addr,
    output logic [31:0] m_granted_count,
    output logic [31:0] m_free_total,
    output logic [6:0]  m_extent_total
);
    localparam int IW = eba_pkg::IDX_W;
    localparam int CW = eba_pkg::CNT_W;
    localparam logic [CW-1:0] MAX_C = CW'(eba_pkg::MAX_EXTENTS);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_A_RD, S_A_CHK, S_F_RD, S_F_CHK, S_F_DEC, S_SD, S_SU, S_RESP
    } state_t;

    state_t state_reg, state_next;
    eba_pkg::extent_t mem [eba_pkg::MAX_EXTENTS];
    eba_pkg::extent_t rdata, wdata, prev_reg, prev_next, nxt_reg, nxt_next;
    logic [IW-1:0] raddr, waddr;
    logic          we;

    logic [31:0] rstart_reg, rend_reg;
    logic [1:0]  op_reg;
    logic [31:0] addr_reg;
    logic [15:0] cnt_reg;
    logic        tail_reg, sp_reg, rec_reg;
    logic [CW-1:0] used_reg, used_next, n_reg, n_next, k_reg, k_next, p_reg, p_next;
    logic [IW-1:0] idx_reg, idx_next, wk_reg, wk_next;
    logic        pend_reg, pend_next, hasn_reg, hasn_next;
    logic [31:0] free_reg, free_next;
    logic [2:0]  st_reg, st_next;
    logic [31:0] ga_reg, ga_next, gc_reg, gc_next;
    logic        mv_reg;
    logic [2:0]  ms_reg;
    logic [31:0] mga_reg, mgc_reg, mft_reg;
    logic [6:0]  met_reg;

    logic [32:0] size33, cnt33, hi33, isize, fsum;
    logic [33:0] hi_p1;
    logic [32:0] prev_p1;
    logic        left, right;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = mv_reg;
    assign m_status        = ms_reg;
    assign m_granted_addr  = mga_reg;
    assign m_granted_count = mgc_reg;
    assign m_free_total    = mft_reg;
    assign m_extent_total  = met_reg;

    assign size33  = {1'b0, rdata.high} - {1'b0, rdata.low} + 33'd1;
    assign cnt33   = {17'd0, cnt_reg};
    assign hi33    = {1'b0, addr_reg} + cnt33 - 33'd1;
    assign hi_p1   = {1'b0, hi33} + 34'd1;
    assign prev_p1 = {1'b0, prev_reg.high} + 33'd1;
    assign isize   = {1'b0, rend_reg} - {1'b0, rstart_reg} + 33'd1;
    assign fsum    = {1'b0, free_reg} + cnt33;
    assign left    = (p_reg != '0) && (prev_p1 == {1'b0, addr_reg});
    assign right   = hasn_reg && (hi_p1 == {2'b00, nxt_reg.low});

    always_comb begin
        state_next = state_reg;
        used_next  = used_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        p_next     = p_reg;
        idx_next   = idx_reg;
        wk_next    = wk_reg;
        pend_next  = 1'b0;
        hasn_next  = hasn_reg;
        free_next  = free_reg;
        st_next    = st_reg;
        ga_next    = ga_reg;
        gc_next    = gc_reg;
        prev_next  = prev_reg;
        nxt_next   = nxt_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = rdata;
        raddr      = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                st_next    = eba_pkg::ST_OK;
                ga_next    = '0;
                gc_next    = '0;
                state_next = S_RESP;
                unique case (op_reg)
                    eba_pkg::OP_INIT: begin
                        used_next = '0;
                        free_next = '0;
                        if (!rec_reg && rstart_reg <= rend_reg) begin
                            we        = 1'b1;
                            waddr     = '0;
                            wdata     = '{low: rstart_reg, high: rend_reg};
                            used_next = CW'(1);
                            free_next = isize[32] ? 32'hFFFF_FFFF : isize[31:0];
                        end
                    end
                    eba_pkg::OP_ALLOC: begin
                        if (cnt_reg == '0) begin
                            st_next = eba_pkg::ST_BADCOUNT;
                        end else if (used_reg == '0 || free_reg == '0) begin
                            st_next = eba_pkg::ST_NOSPACE;
                        end else begin
                            n_next     = '0;
                            idx_next   = tail_reg ? IW'(used_reg - CW'(1)) : '0;
                            state_next = S_A_RD;
                        end
                    end
                    eba_pkg::OP_FREE: begin
                        if (cnt_reg == '0) begin
                            st_next = eba_pkg::ST_BADCOUNT;
                        end else if (addr_reg < rstart_reg || hi33 > {1'b0, rend_reg}) begin
                            st_next = eba_pkg::ST_RANGE;
                        end else begin
                            p_next     = '0;
                            hasn_next  = 1'b0;
                            state_next = (used_reg == '0) ? S_F_DEC : S_F_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_A_RD: begin
                raddr      = idx_reg;
                state_next = S_A_CHK;
            end
            S_A_CHK: begin
                if (cnt33 >= size33 && sp_reg && cnt33 > size33) begin
                    n_next = n_reg + CW'(1);
                    if (n_reg + CW'(1) == used_reg) begin
                        st_next    = eba_pkg::ST_NOSPACE;
                        state_next = S_RESP;
                    end else begin
                        idx_next   = tail_reg ? idx_reg - IW'(1) : idx_reg + IW'(1);
                        state_next = S_A_RD;
                    end
                end else if (cnt33 >= size33) begin
                    ga_next    = rdata.low;
                    gc_next    = size33[31:0];
                    free_next  = ({1'b0, free_reg} > size33) ? free_reg - size33[31:0] : '0;
                    k_next     = CW'(idx_reg) + CW'(1);
                    state_next = S_SD;
                end else begin
                    we    = 1'b1;
                    waddr = idx_reg;
                    if (tail_reg) begin
                        ga_next    = rdata.high + 32'd1 - 32'(cnt_reg);
                        wdata.high = rdata.high - 32'(cnt_reg);
                    end else begin
                        ga_next   = rdata.low;
                        wdata.low = rdata.low + 32'(cnt_reg);
                    end
                    gc_next    = 32'(cnt_reg);
                    free_next  = (free_reg > 32'(cnt_reg)) ? free_reg - 32'(cnt_reg) : '0;
                    state_next = S_RESP;
                end
            end
            S_F_RD: begin
                raddr      = p_reg[IW-1:0];
                state_next = S_F_CHK;
            end
            S_F_CHK: begin
                if (rdata.high < addr_reg) begin
                    prev_next = rdata;
                    p_next    = p_reg + CW'(1);
                    state_next = (p_reg + CW'(1) == used_reg) ? S_F_DEC : S_F_RD;
                end else begin
                    nxt_next   = rdata;
                    hasn_next  = 1'b1;
                    state_next = S_F_DEC;
                end
            end
            S_F_DEC: begin
                state_next = S_RESP;
                free_next  = fsum[32] ? 32'hFFFF_FFFF : fsum[31:0];
                if (hasn_reg && {1'b0, nxt_reg.low} <= hi33) begin
                    st_next   = eba_pkg::ST_OVERLAP;
                    free_next = free_reg;
                end else if (left && right) begin
                    we         = 1'b1;
                    waddr      = IW'(p_reg - CW'(1));
                    wdata      = '{low: prev_reg.low, high: nxt_reg.high};
                    k_next     = p_reg + CW'(1);
                    state_next = S_SD;
                end else if (left) begin
                    we    = 1'b1;
                    waddr = IW'(p_reg - CW'(1));
                    wdata = '{low: prev_reg.low, high: hi33[31:0]};
                end else if (right) begin
                    we    = 1'b1;
                    waddr = p_reg[IW-1:0];
                    wdata = '{low: addr_reg, high: nxt_reg.high};
                end else if (used_reg >= MAX_C) begin
                    st_next   = eba_pkg::ST_FULL;
                    free_next = free_reg;
                end else begin
                    k_next     = used_reg;
                    state_next = S_SU;
                end
            end
            S_SD: begin
                raddr = k_reg[IW-1:0];
                if (pend_reg) begin
                    we    = 1'b1;
                    waddr = wk_reg;
                end
                if (k_reg < used_reg) begin
                    pend_next = 1'b1;
                    wk_next   = IW'(k_reg - CW'(1));
                    k_next    = k_reg + CW'(1);
                end else if (!pend_reg) begin
                    used_next  = used_reg - CW'(1);
                    state_next = S_RESP;
                end
            end
            S_SU: begin
                raddr = IW'(k_reg - CW'(1));
                if (pend_reg) begin
                    we    = 1'b1;
                    waddr = wk_reg;
                end
                if (k_reg > p_reg) begin
                    pend_next = 1'b1;
                    wk_next   = k_reg[IW-1:0];
                    k_next    = k_reg - CW'(1);
                end else if (!pend_reg) begin
                    we         = 1'b1;
                    waddr      = p_reg[IW-1:0];
                    wdata      = '{low: addr_reg, high: hi33[31:0]};
                    used_next  = used_reg + CW'(1);
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!mv_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            free_reg   <= '0;
            pend_reg   <= 1'b0;
            mv_reg     <= 1'b0;
            rstart_reg <= '0;
            rend_reg   <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            free_reg  <= free_next;
            pend_reg  <= pend_next;
            if (cfg_valid) begin
                if (cfg_index == eba_pkg::CFG_START) begin
                    rstart_reg <= cfg_data;
                end else begin
                    rend_reg <= cfg_data;
                end
            end
            if (state_reg == S_RESP && (!mv_reg || m_ready)) begin
                mv_reg  <= 1'b1;
                ms_reg  <= st_reg;
                mga_reg <= ga_reg;
                mgc_reg <= gc_reg;
                mft_reg <= free_reg;
                met_reg <= 7'(used_reg);
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
        if (state_reg == S_IDLE && s_valid) begin
            op_reg   <= s_op;
            addr_reg <= s_block_addr;
            cnt_reg  <= s_count;
            tail_reg <= s_from_tail;
            sp_reg   <= s_superpage;
            rec_reg  <= s_recovery;
        end
        n_reg    <= n_next;
        k_reg    <= k_next;
        p_reg    <= p_next;
        idx_reg  <= idx_next;
        wk_reg   <= wk_next;
        hasn_reg <= hasn_next;
        st_reg   <= st_next;
        ga_reg   <= ga_next;
        gc_reg   <= gc_next;
        prev_reg <= prev_next;
        nxt_reg  <= nxt_next;
    end

    `EBA_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= MAX_C)
    `EBA_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)
    `EBA_ASSERT_NOW(a_insert_room, state_reg == S_SU, used_reg < MAX_C)
    `EBA_ASSERT_NOW(a_drop_nonempty, state_reg == S_SD, used_reg != '0)
endmodule
